/* rtl/core/sha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Commands, controller states, command/status structs and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned PadLimit   = 56;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned CountW     = 61;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_ABSORB  = 2'd1,
    CMD_DIGEST  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       restart;     // load initial hash, clear count
    logic       absorb;      // write byte, bump count
    logic       start_blk;   // build working block, begin compression
    logic       pad_mode;    // build padded block instead of raw buffer
    logic       pad_second;  // second padded block (zeros plus length)
    logic       from_work;   // start from working hash instead of stored
    logic       round_en;    // run one round
    logic       fold;        // add working vars into working hash
    logic       commit;      // store folded working hash as stored hash
    logic [5:0] round_idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [5:0] fill;
  } dp_sts_t;

  localparam logic [31:0] InitWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundKeys [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

/* rtl/core/sha_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorb, block compression, padding passes and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic [1:0]       req_cmd_i,
  input  sha_pkg::dp_sts_t sts_i,
  output sha_pkg::dp_cmd_t cmd_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       out_idx_o
);
  import sha_pkg::*;

  state_e     state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       digest_q, digest_d;   // compression belongs to a digest
  logic       second_q, second_d;   // a second padded block still follows
  logic       pass2_q, pass2_d;     // current block is the second padded one
  logic       accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_idx_o   = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rnd_q    <= '0;
      idx_q    <= '0;
      digest_q <= 1'b0;
      second_q <= 1'b0;
      pass2_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rnd_q    <= rnd_d;
      idx_q    <= idx_d;
      digest_q <= digest_d;
      second_q <= second_d;
      pass2_q  <= pass2_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    rnd_d    = rnd_q;
    idx_d    = idx_q;
    digest_d = digest_q;
    second_d = second_q;
    pass2_d  = pass2_q;
    cmd_o    = '0;
    cmd_o.round_idx  = rnd_q;
    cmd_o.pad_mode   = digest_q;
    cmd_o.pad_second = pass2_q;
    cmd_o.from_work  = pass2_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(req_cmd_i))
            CMD_RESTART: cmd_o.restart = 1'b1;
            CMD_ABSORB: begin
              cmd_o.absorb = 1'b1;
              if (sts_i.fill == 6'd63) begin
                digest_d = 1'b0;
                pass2_d  = 1'b0;
                state_d  = ST_LOAD;
              end
            end
            CMD_DIGEST: begin
              digest_d = 1'b1;
              pass2_d  = 1'b0;
              second_d = (sts_i.fill >= 6'(PadLimit));
              state_d  = ST_LOAD;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.start_blk = 1'b1;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(Rounds - 1)) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (!digest_q) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end else if (second_q && !pass2_q) begin
          pass2_d = 1'b1;
          state_d = ST_LOAD;
        end else begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/sha_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, byte count, hash words, message schedule and round logic.
// ----------------------------------------------------------------------------
module sha_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       data_i,
  input  sha_pkg::dp_cmd_t cmd_i,
  output sha_pkg::dp_sts_t sts_o,
  input  logic [2:0]       out_idx_i,
  output logic [31:0]      out_word_o
);
  import sha_pkg::*;

  logic [7:0]        buf_q [BlockBytes];
  logic [CountW-1:0] count_q;
  logic [31:0]       hash_q [8];
  logic [31:0]       work_q [8];   // working hash for this compression
  logic [31:0]       v_q [8];
  logic [31:0]       w_q [16];     // rolling schedule window
  logic              init_q;
  logic [5:0]        fill;
  logic [63:0]       bits;
  logic [7:0]        blk [BlockBytes];
  logic [31:0]       wt, s0, s1, wnew, ch, maj, t1, t2, e, a;

  assign fill = count_q[5:0];
  assign sts_o.fill = fill;
  assign bits = {count_q, 3'b000};
  assign out_word_o = work_q[out_idx_i];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // block as presented to the compression
  always_comb begin
    for (int i = 0; i < BlockBytes; i++) begin
      if (!cmd_i.pad_mode) blk[i] = buf_q[i];
      else if (cmd_i.pad_second) blk[i] = 8'h00;
      else if (6'(i) < fill) blk[i] = buf_q[i];
      else if (6'(i) == fill) blk[i] = 8'h80;
      else blk[i] = 8'h00;
    end
    if (cmd_i.pad_mode && (cmd_i.pad_second || fill < 6'(PadLimit))) begin
      for (int i = 0; i < 8; i++) blk[PadLimit + i] = bits[63 - 8*i -: 8];
    end
  end

  always_comb begin
    wt   = w_q[0];
    s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    e    = v_q[4];
    a    = v_q[0];
    ch   = (e & v_q[5]) ^ (~e & v_q[6]);
    maj  = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1   = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch
         + RoundKeys[cmd_i.round_idx] + wt;
    t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      init_q  <= 1'b1;
    end else if (cmd_i.restart) begin
      count_q <= '0;
      init_q  <= 1'b1;
    end else begin
      if (cmd_i.absorb) count_q <= count_q + CountW'(1);
      if (cmd_i.commit) init_q <= 1'b0;
    end
  end

  // stored hash reads as the initial words until the first block commits
  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb) buf_q[fill] <= data_i;
    // commit comes with the fold, so store the folded sum directly
    if (cmd_i.commit) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= work_q[i] + v_q[i];
    end
    if (cmd_i.start_blk) begin
      for (int i = 0; i < 16; i++)
        w_q[i] <= {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      if (!cmd_i.from_work) begin
        for (int i = 0; i < 8; i++) begin
          work_q[i] <= init_q ? InitWords[i] : hash_q[i];
          v_q[i]    <= init_q ? InitWords[i] : hash_q[i];
        end
      end else begin
        v_q <= work_q;
      end
    end
    if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) work_q[i] <= work_q[i] + v_q[i];
    end
  end

endmodule

/* rtl/core/sha256_hash_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// The absorb that fills a block runs a compression (one round per cycle in
// the round unit) before the next request is taken. Digest compresses one
// padded block, or two when padding spills into a second block, then emits
// 8 output words at one per cycle while the output is ready. Reset loads the
// standard initial hash and clears the byte count; the block buffer is not cleared.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] command, [9:2] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast
);
  import sha_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [2:0]  idx;
  logic [31:0] word;

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_cmd_i   (s_axis_tdata[1:0]),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_idx_o   (idx)
  );

  sha_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .data_i     (s_axis_tdata[9:2]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_idx_i  (idx),
    .out_word_o (word)
  );

  assign m_axis_tdata = {5'b0, idx, word};
  assign m_axis_tlast = (idx == 3'd7);

endmodule

/* verif/sha256_hash_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 engine stream checker
// Watches both stream ports, keeps its own copy of the hash state, predicts
// the eight digest words of every digest request and compares the output
// stream word by word, in order.
// ----------------------------------------------------------------------------
module sha256_hash_engine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] command, [9:2] data_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  input  logic        m_axis_tlast,
  output int          errors_o,
  output int          pending_o,
  output int          digests_o
);
  import sha_pkg::*;

  typedef logic [31:0] hash_t [8];
  typedef logic [7:0]  block_t [64];

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  hash_t          hash_state;
  block_t         msg_block;
  logic [60:0]    byte_count;
  digest_word_t   digest_q[$];

  assign pending_o = digest_q.size();

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic hash_t sha_compress(input hash_t hw, input block_t blk);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, maj;
    hash_t       res;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hw[i];
    for (int i = 0; i < 64; i++) begin
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1  = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch
            + RoundKeys[i] + w[i];
      t2  = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + maj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) res[i] = hw[i] + v[i];
    return res;
  endfunction

  task automatic predict_request(input cmd_e cmd, input logic [7:0] data);
    hash_t        hw;
    block_t       blk;
    logic [5:0]   fill;
    logic [63:0]  bits;
    digest_word_t dw;
    fill = byte_count[5:0];
    case (cmd)
      CMD_RESTART: begin
        for (int i = 0; i < 8; i++) hash_state[i] = InitWords[i];
        byte_count = '0;
      end
      CMD_ABSORB: begin
        msg_block[fill] = data;
        byte_count = byte_count + 1'b1;
        if (fill == 6'd63) hash_state = sha_compress(hash_state, msg_block);
      end
      CMD_DIGEST: begin
        hw   = hash_state;
        bits = {byte_count, 3'b000};
        for (int i = 0; i < 64; i++) blk[i] = (i < fill) ? msg_block[i] : 8'h00;
        blk[fill] = 8'h80;
        if (fill >= PadLimit) begin
          hw = sha_compress(hw, blk);
          for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
        hw = sha_compress(hw, blk);
        for (int i = 0; i < 8; i++) begin
          dw.word  = hw[i];
          dw.index = i[2:0];
          dw.last  = (i == 7);
          digest_q.push_back(dw);
        end
        digests_o++;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t exp_w;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_state[i] = InitWords[i];
      byte_count = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_request(cmd_e'(s_axis_tdata[1:0]), s_axis_tdata[9:2]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected word: actual word=%h index=%0d last=%b",
                   $time, m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
          errors_o++;
        end else begin
          exp_w = digest_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_w.word || m_axis_tdata[34:32] !== exp_w.index ||
              m_axis_tlast !== exp_w.last) begin
            $display("%0t: mismatch: expected word=%h index=%0d last=%b,",
                     $time, exp_w.word, exp_w.index, exp_w.last);
            $display("    actual word=%h index=%0d last=%b",
                     m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
            errors_o++;
          end
        end
      end
    end
  end

  initial begin
    errors_o  = 0;
    digests_o = 0;
  end

endmodule

/* verif/sha256_hash_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 engine testbench
// Drives restart, absorb, digest and unused-command requests with random gaps and output
// stalls; the checker predicts every digest word and counts failures.
// ----------------------------------------------------------------------------
module sha256_hash_engine_tb;
  import sha_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  int errors, pending, digests;
  int sent = 0;
  int src_idle;
  int sink_idle;
  int msg_len;

  always #6 clk_i = ~clk_i;

  sha256_hash_engine uut (.*);

  sha256_hash_engine_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .errors_o(errors), .pending_o(pending), .digests_o(digests)
  );

  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);

  // idle mix by progress: sink-heavy, then sender-heavy, then none
  always_comb begin
    if (sent < 80) begin
      src_idle = 38; sink_idle = 45;
    end else if (sent < 160) begin
      src_idle = 45; sink_idle = 38;
    end else begin
      src_idle = 0; sink_idle = 0;
    end
  end

  task automatic send_req(input cmd_e cmd, input logic [7:0] data);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, data, cmd};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic absorb_run(input int n);
    for (int i = 0; i < n; i++) send_req(CMD_ABSORB, 8'($urandom));
  endtask

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int msgs;
    msgs = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, unused command, byte extremes
    send_req(CMD_DIGEST, 8'h00);
    send_req(CMD_NONE, 8'hFF);
    send_req(CMD_DIGEST, 8'hA5);
    send_req(CMD_ABSORB, 8'h00);
    send_req(CMD_ABSORB, 8'hFF);
    send_req(CMD_DIGEST, 8'h00);
    send_req(CMD_ABSORB, 8'h55);
    send_req(CMD_NONE, 8'h00);
    send_req(CMD_DIGEST, 8'hFF);
    send_req(CMD_RESTART, 8'hFF);
    send_req(CMD_DIGEST, 8'h00);
    send_req(CMD_ABSORB, 8'hAA);
    send_req(CMD_RESTART, 8'h00);
    send_req(CMD_DIGEST, 8'h00);

    // random messages, lengths biased toward the padding boundaries
    while (sent < 200) begin
      send_req(CMD_RESTART, 8'($urandom));
      case ($urandom_range(0, 5))
        0: msg_len = 55;
        1: msg_len = 56;
        2: msg_len = 63;
        3: msg_len = 64;
        4: msg_len = $urandom_range(0, 12);
        default: msg_len = $urandom_range(100, 130);
      endcase
      for (int i = 0; i < msg_len && sent < 206; i++) begin
        if ($urandom_range(0, 99) < 4) send_req(CMD_DIGEST, 8'($urandom));
        if ($urandom_range(0, 99) < 3) send_req(CMD_NONE, 8'($urandom));
        send_req(CMD_ABSORB, 8'($urandom));
      end
      send_req(CMD_DIGEST, 8'($urandom));
      msgs++;
      if (msgs == 2) begin
        // drain all digests before continuing
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk_i);
        absorb_run(3);
        send_req(CMD_DIGEST, 8'h00);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d requests over %0d messages; %0d digests checked.",
             sent, msgs, digests);
    $display("Lengths around the 55/56 and 63/64 byte padding limits were covered.");
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
